>>> rtl/core/dd2b96_pkg.sv
// constants, microcode word layout and control store for the decimal to binary converter
package dd2b96_pkg;

  localparam int DIGIT_COUNT = 30;
  localparam int BIT_COUNT   = 96;

  localparam int ALL_DIGITS = 30;
  localparam int FIELD_W    = 60;
  localparam int RES_W      = 96;
  localparam int WORD_W     = 32;
  localparam int DIG_W      = 4 * DIGIT_COUNT;
  localparam int IN_DATA_W  = 2 * FIELD_W;
  localparam int OUT_DATA_W = 3 * WORD_W;
  localparam int USER_W     = 2;

  localparam int CNT_W = (BIT_COUNT > 1) ? $clog2(BIT_COUNT) : 1;
  localparam logic [CNT_W-1:0] COUNT_LAST = CNT_W'(BIT_COUNT - 1);

  // sequencer steps
  localparam int PC_W = 2;
  localparam logic [PC_W-1:0] STEP_LOAD  = 2'd0;
  localparam logic [PC_W-1:0] STEP_SHIFT = 2'd1;
  localparam logic [PC_W-1:0] STEP_EMIT  = 2'd2;

  // jump conditions
  localparam int COND_W = 2;
  localparam logic [COND_W-1:0] COND_NEVER    = 2'd0;
  localparam logic [COND_W-1:0] COND_WAIT_IN  = 2'd1;
  localparam logic [COND_W-1:0] COND_MORE     = 2'd2;
  localparam logic [COND_W-1:0] COND_WAIT_OUT = 2'd3;

  typedef struct packed {
    logic              load;
    logic              shift;
    logic              emit;
    logic [COND_W-1:0] cond;
    logic [PC_W-1:0]   jump;
    logic [PC_W-1:0]   next;
  } ucode_t;

  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w = '0;
    case (pc)
      STEP_LOAD: begin
        w.load = 1'b1;
        w.cond = COND_WAIT_IN;
        w.jump = STEP_LOAD;
        w.next = STEP_SHIFT;
      end
      STEP_SHIFT: begin
        w.shift = 1'b1;
        w.cond  = COND_MORE;
        w.jump  = STEP_SHIFT;
        w.next  = STEP_EMIT;
      end
      STEP_EMIT: begin
        w.emit = 1'b1;
        w.cond = COND_WAIT_OUT;
        w.jump = STEP_EMIT;
        w.next = STEP_LOAD;
      end
      default: begin
        w.cond = COND_NEVER;
        w.next = STEP_LOAD;
      end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/decimal_digits_to_binary96_unit.sv
// packed bcd to 96-bit binary converter, microcoded shift-and-correct sequencer
//
// usage:
//   s_axis carries one request per number: 30 bcd digits, most significant first.
//   m_axis returns one result per request: three 32-bit words of the binary value
//   plus overflow and bad_digit flags in tuser.
//   the datapath is a reverse double-dabble: each cycle the bcd register shifts
//   one bit right into the binary register and every digit of 8 or more drops 3.
//   after the accepting edge the sequencer repeats the shift step once per
//   result bit, all on the single shared shift/correct unit, then runs the emit
//   step. s_axis_tready is high only in the load step, so a new request is not
//   taken until the emit step of the previous one has finished.
//   a finished result sits in the output register; the next request is accepted
//   and converted while it waits. if the result is still not taken when the
//   next one is done, the sequencer holds in the emit step.
//   reset (rst, synchronous) returns the sequencer to the load step and empties
//   the output register.
module decimal_digits_to_binary96_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [dd2b96_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // digits_high, digits_low
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [dd2b96_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // word_low, word_mid, word_high
  output logic [dd2b96_pkg::USER_W-1:0]        m_axis_tuser   // bad_digit, overflow
);

  logic [dd2b96_pkg::PC_W-1:0]  pc;
  logic [dd2b96_pkg::PC_W-1:0]  pc_next;
  dd2b96_pkg::ucode_t           uw;
  logic                         cond_hit;

  logic [dd2b96_pkg::CNT_W-1:0] cnt;
  logic [dd2b96_pkg::DIG_W-1:0] bcd;
  logic [dd2b96_pkg::DIG_W-1:0] bcd_next;
  logic [dd2b96_pkg::BIT_COUNT-1:0] bin;
  logic [dd2b96_pkg::BIT_COUNT-1:0] bin_next;
  logic                         bad;
  logic                         bad_next;

  logic [dd2b96_pkg::IN_DATA_W-1:0] digits;
  logic                         load_en;
  logic                         shift_en;
  logic                         emit_en;
  logic                         out_room;
  logic                         ovf;
  logic [dd2b96_pkg::RES_W-1:0] res;

  assign uw       = dd2b96_pkg::ucode_rom(pc);
  assign out_room = !m_axis_tvalid || m_axis_tready;
  assign load_en  = uw.load && s_axis_tvalid;
  assign shift_en = uw.shift;
  assign emit_en  = uw.emit && out_room;

  assign s_axis_tready = uw.load;

  always_comb begin
    case (uw.cond)
      dd2b96_pkg::COND_NEVER:    cond_hit = 1'b0;
      dd2b96_pkg::COND_WAIT_IN:  cond_hit = !s_axis_tvalid;
      dd2b96_pkg::COND_MORE:     cond_hit = (cnt != dd2b96_pkg::COUNT_LAST);
      dd2b96_pkg::COND_WAIT_OUT: cond_hit = !out_room;
      default:                   cond_hit = 1'b0;
    endcase
    pc_next = cond_hit ? uw.jump : uw.next;
  end

  // digits_low above digits_high, so the digits_high field lands in the bottom nibbles
  assign digits = {s_axis_tdata[dd2b96_pkg::FIELD_W-1:0],
                   s_axis_tdata[dd2b96_pkg::IN_DATA_W-1:dd2b96_pkg::FIELD_W]};

  always_comb begin
    bad_next = 1'b0;
    for (int i = 0; i < dd2b96_pkg::DIGIT_COUNT; i++) begin
      if (digits[4*i +: 4] > 4'd9) bad_next = 1'b1;
    end
  end

  // shift one bit out of the bcd value, then fix every digit that came out 8 or more
  always_comb begin
    logic [dd2b96_pkg::DIG_W-1:0] shifted;
    logic [3:0] nib;
    shifted  = bcd >> 1;
    bcd_next = shifted;
    for (int i = 0; i < dd2b96_pkg::DIGIT_COUNT; i++) begin
      nib = shifted[4*i +: 4];
      if (nib >= 4'd8) bcd_next[4*i +: 4] = nib - 4'd3;
    end
    bin_next = dd2b96_pkg::BIT_COUNT'({bcd[0], bin} >> 1);
  end

  assign ovf = (bcd != '0);

  always_comb begin
    if (bad) res = '0;
    else if (ovf) res = dd2b96_pkg::RES_W'({dd2b96_pkg::BIT_COUNT{1'b1}});
    else res = dd2b96_pkg::RES_W'(bin);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc  <= dd2b96_pkg::STEP_LOAD;
      cnt <= '0;
    end else begin
      pc <= pc_next;
      if (load_en) cnt <= '0;
      else if (shift_en && cnt != dd2b96_pkg::COUNT_LAST) cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      bcd <= digits[dd2b96_pkg::DIG_W-1:0];
      bin <= '0;
      bad <= bad_next;
    end else if (shift_en) begin
      bcd <= bcd_next;
      bin <= bin_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit_en) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_en) begin
      m_axis_tdata <= {res[dd2b96_pkg::WORD_W-1:0],
                       res[2*dd2b96_pkg::WORD_W-1:dd2b96_pkg::WORD_W],
                       res[3*dd2b96_pkg::WORD_W-1:2*dd2b96_pkg::WORD_W]};
      m_axis_tuser <= {bad, ovf && !bad};
    end
  end

  a_emit_after_all_shifts: assert property (@(posedge clk) disable iff (rst)
    pc == dd2b96_pkg::STEP_EMIT |-> cnt == dd2b96_pkg::COUNT_LAST)
    else $error("emit step reached before all bits were shifted");

  a_no_load_and_emit: assert property (@(posedge clk) disable iff (rst)
    !(load_en && emit_en))
    else $error("request accepted in the same cycle a result is emitted");

  a_emit_fills_output: assert property (@(posedge clk) disable iff (rst)
    emit_en |=> m_axis_tvalid)
    else $error("emitted result missing from output register");

  a_bad_digit_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '0 && !m_axis_tuser[0])
    else $error("bad digit result not forced to zero");

  a_load_clears_count: assert property (@(posedge clk) disable iff (rst)
    load_en |=> cnt == '0 && pc == dd2b96_pkg::STEP_SHIFT)
    else $error("accepted request did not start the shift loop");

endmodule
